// File: sv/gcc_pkg.sv
// Shared constants, types and elaboration-time tables for the gas concentration converter.
`timescale 1ns / 1ps

package gcc_pkg;

    localparam int ADC_FULL_SCALE_DEF = 1023;
    localparam int FRAC_BITS_DEF      = 16;

    localparam int LOG_FB      = 30;
    localparam int LOG_LAT     = LOG_FB + 1;
    localparam int EXPO_W      = 13;
    localparam int EXPO_SCALE  = 1000;
    localparam int COEF_W      = 37;
    localparam int FIFO_DEPTH  = 4;
    localparam int GAS_W       = 3;
    localparam int READING_W   = 10;
    localparam int CONC_W      = 32;

    localparam logic [1:0] CFG_NH3 = 2'd0;
    localparam logic [1:0] CFG_CO  = 2'd1;
    localparam logic [1:0] CFG_NO2 = 2'd2;

    localparam logic [1:0] CHAN_NH3 = 2'd0;
    localparam logic [1:0] CHAN_CO  = 2'd1;
    localparam logic [1:0] CHAN_NO2 = 2'd2;

    localparam logic [READING_W-1:0] BASELINE_RST = 10'd512;

    typedef enum logic [1:0] {
        KIND_NORM,
        KIND_INF,
        KIND_ZERO,
        KIND_SAT
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_INF = 2'd1,
        STATUS_SAT = 2'd2
    } t_status;

    typedef struct packed {
        t_kind            kind;
        logic [GAS_W-1:0] gas;
    } t_tag;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [GAS_W-1:0] gas;
    } t_ctl;

    localparam logic [1:0] GAS_CHAN [8] = '{
        CHAN_NH3, CHAN_CO, CHAN_NO2, CHAN_NH3, CHAN_NH3, CHAN_CO, CHAN_CO, CHAN_CO
    };
    localparam logic [EXPO_W-1:0] GAS_EXPO_MAG [8] = '{
        13'd1670, 13'd1179, 13'd1007, 13'd2518, 13'd2138, 13'd4363, 13'd1800, 13'd1552
    };
    localparam logic GAS_EXPO_NEG [8] = '{
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };
    localparam logic [19:0] GAS_CNUM [8] = '{
        20'd100, 20'd4385, 20'd1000, 20'd570164, 20'd398107, 20'd630957, 20'd73, 20'd1622
    };
    localparam logic [19:0] GAS_CDEN [8] = '{
        20'd147, 20'd1000, 20'd6855, 20'd1000, 20'd1000, 20'd1000, 20'd100, 20'd1000
    };

    function automatic logic [63:0] f_log2(input logic [63:0] x);
        logic [63:0] m;
        logic [63:0] frac;
        int          e;
        logic        found;
        e     = 0;
        found = 1'b0;
        for (int i = 63; i > 0; i--) begin
            if (x[i] && !found) begin
                e     = i;
                found = 1'b1;
            end
        end
        if (e <= 31) m = x << (31 - e);
        else m = x >> (e - 31);
        frac = 64'd0;
        for (int i = 0; i < LOG_FB; i++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(e) << LOG_FB) + frac;
    endfunction

    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = 64'd0;
        b   = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] f_exp_r(input int n);
        logic [63:0] r;
        r = f_isqrt(64'd2 << 60);
        for (int i = 1; i < n; i++) begin
            r = f_isqrt(r << LOG_FB);
        end
        return r;
    endfunction

    function automatic logic signed [COEF_W-1:0] f_coef_log(input int g);
        logic signed [64:0] d;
        d = $signed({1'b0, f_log2(64'(GAS_CNUM[g]))}) - $signed({1'b0, f_log2(64'(GAS_CDEN[g]))});
        return COEF_W'(d);
    endfunction

    localparam logic signed [COEF_W-1:0] COEF_LOG [8] = '{
        f_coef_log(0), f_coef_log(1), f_coef_log(2), f_coef_log(3),
        f_coef_log(4), f_coef_log(5), f_coef_log(6), f_coef_log(7)
    };

endpackage

// File: sv/gcc_front.sv
// Front end: baseline registers, clamping, ratio terms and special-case classification.
`timescale 1ns / 1ps

module gcc_front #(
    parameter int ADC_FULL_SCALE = gcc_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [gcc_pkg::GAS_W-1:0]                 i_gas_select,
    input  logic [gcc_pkg::READING_W-1:0]             i_channel_reading,
    input  logic                                      i_cfg_we,
    input  logic [1:0]                                i_cfg_idx,
    input  logic [gcc_pkg::READING_W-1:0]             i_cfg_data,
    output logic                                      o_push,
    input  logic                                      i_full,
    output gcc_pkg::t_tag                             o_tag,
    output logic [2*$clog2(ADC_FULL_SCALE+1)-1:0]     o_num,
    output logic [2*$clog2(ADC_FULL_SCALE+1)-1:0]     o_den
);

    localparam int FW = $clog2(ADC_FULL_SCALE + 1);
    localparam int NW = 2 * FW;
    localparam int AW = (FW > gcc_pkg::READING_W) ? FW : gcc_pkg::READING_W;
    localparam logic [AW-1:0] FS_A = AW'(ADC_FULL_SCALE);
    localparam logic [FW-1:0] FS_F = FW'(ADC_FULL_SCALE);

    logic [gcc_pkg::READING_W-1:0] r_base_nh3;
    logic [gcc_pkg::READING_W-1:0] r_base_co;
    logic [gcc_pkg::READING_W-1:0] r_base_no2;

    logic                 r_valid;
    gcc_pkg::t_tag        r_tag;
    logic [NW-1:0]        r_num;
    logic [NW-1:0]        r_den;

    logic [gcc_pkg::READING_W-1:0] w_base;
    logic [AW-1:0]        w_an_w;
    logic [AW-1:0]        w_a0_w;
    logic [FW-1:0]        w_an;
    logic [FW-1:0]        w_a0;
    logic                 w_num_zero;
    logic                 w_den_zero;
    gcc_pkg::t_tag        n_tag;
    logic [NW-1:0]        n_num;
    logic [NW-1:0]        n_den;
    logic                 w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_nh3 <= gcc_pkg::BASELINE_RST;
            r_base_co  <= gcc_pkg::BASELINE_RST;
            r_base_no2 <= gcc_pkg::BASELINE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == gcc_pkg::CFG_NH3) r_base_nh3 <= i_cfg_data;
            if (i_cfg_idx == gcc_pkg::CFG_CO)  r_base_co  <= i_cfg_data;
            if (i_cfg_idx == gcc_pkg::CFG_NO2) r_base_no2 <= i_cfg_data;
        end
    end

    always_comb begin
        unique case (gcc_pkg::GAS_CHAN[i_gas_select])
            gcc_pkg::CHAN_NH3: w_base = r_base_nh3;
            gcc_pkg::CHAN_CO:  w_base = r_base_co;
            default:           w_base = r_base_no2;
        endcase
        w_an_w = AW'(i_channel_reading);
        w_a0_w = AW'(w_base);
        w_an   = (w_an_w > FS_A) ? FS_F : FW'(w_an_w);
        w_a0   = (w_a0_w > FS_A) ? FS_F : FW'(w_a0_w);
        w_num_zero = (w_an == '0) || (w_a0 == FS_F);
        w_den_zero = (w_a0 == '0) || (w_an == FS_F);
        n_num = NW'(w_an) * NW'(FS_F - w_a0);
        n_den = NW'(w_a0) * NW'(FS_F - w_an);
        n_tag.gas = i_gas_select;
        if (w_den_zero) n_tag.kind = gcc_pkg::KIND_INF;
        else if (w_num_zero && gcc_pkg::GAS_EXPO_NEG[i_gas_select]) n_tag.kind = gcc_pkg::KIND_INF;
        else if (w_num_zero) n_tag.kind = gcc_pkg::KIND_ZERO;
        else n_tag.kind = gcc_pkg::KIND_NORM;
    end

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tag <= n_tag;
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    assign o_tag = r_tag;
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

// File: sv/gcc_fifo.sv
// Short queue between the front end and the evaluation pipeline.
`timescale 1ns / 1ps

module gcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gcc_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (w_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !w_pop) r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

// File: sv/gcc_log2.sv
// Pipelined fixed-point log2: normalize, then one squaring stage per fraction bit.
`timescale 1ns / 1ps

module gcc_log2 #(
    parameter int NW  = 20,
    parameter int E_W = 5
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [NW-1:0]                 i_x,
    output logic [E_W+gcc_pkg::LOG_FB-1:0] o_log
);

    localparam int FB = gcc_pkg::LOG_FB;

    logic [31:0]   r_m [FB+1];
    logic [FB-1:0] r_f [FB+1];
    logic [E_W-1:0] r_e [FB+1];

    logic [E_W-1:0] w_e;

    always_comb begin
        w_e = '0;
        for (int i = 1; i < NW; i++) begin
            if (i_x[i]) w_e = E_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0] <= w_e;
            r_m[0] <= 32'(i_x) << (5'd31 - 5'(w_e));
            r_f[0] <= '0;
        end
    end

    for (genvar k = 1; k <= FB; k++) begin : g_sq
        logic [63:0] w_sq;
        logic [32:0] w_s;
        assign w_sq = 64'(r_m[k-1]) * 64'(r_m[k-1]);
        assign w_s  = w_sq[63:31];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_e[k] <= r_e[k-1];
                r_m[k] <= w_s[32] ? w_s[32:1] : w_s[31:0];
                r_f[k] <= {r_f[k-1][FB-2:0], w_s[32]};
            end
        end
    end

    assign o_log = {r_e[FB], r_f[FB]};

endmodule

// File: sv/gcc_back.sv
// Evaluation pipeline: log ratio, exponent scaling, divide by 1000, exp2 and output register.
`timescale 1ns / 1ps

module gcc_back #(
    parameter int NW        = 20,
    parameter int FRAC_BITS = gcc_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_pop,
    input  gcc_pkg::t_tag              i_tag,
    input  logic [NW-1:0]              i_num,
    input  logic [NW-1:0]              i_den,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [gcc_pkg::CONC_W-1:0] o_concentration,
    output logic [1:0]                 o_status
);

    localparam int FB    = gcc_pkg::LOG_FB;
    localparam int E_W   = $clog2(NW);
    localparam int LOG_W = E_W + FB;
    localparam int PM_W  = LOG_W + gcc_pkg::EXPO_W;
    localparam int ZW    = PM_W + 2;
    localparam int NLAT  = gcc_pkg::LOG_LAT;
    localparam logic signed [ZW-1:0] FRAC_OFF = ZW'(FRAC_BITS) <<< FB;

    localparam int DIV_ST = 4;
    localparam int DIV_L  = $clog2(gcc_pkg::EXPO_SCALE);
    localparam int DIV_S  = PM_W + DIV_L;
    localparam int M_W    = PM_W + 1;
    localparam int HW     = 24;
    localparam int XH_W   = PM_W - HW;
    localparam int MH_W   = M_W - HW;
    localparam int PHH_W  = XH_W + MH_W;
    localparam int PHL_W  = XH_W + HW;
    localparam int PLH_W  = HW + MH_W;
    localparam int PLL_W  = 2 * HW;
    localparam int SUM_W  = PM_W + M_W;
    localparam int QUO_W  = SUM_W - DIV_S;
    localparam logic [63:0] DIV_M64 =
        ((64'd1 << DIV_S) + 64'(gcc_pkg::EXPO_SCALE) - 64'd1) / 64'(gcc_pkg::EXPO_SCALE);
    localparam logic [M_W-1:0]  DIV_M  = M_W'(DIV_M64);
    localparam logic [MH_W-1:0] DIV_MH = DIV_M[M_W-1:HW];
    localparam logic [HW-1:0]   DIV_ML = DIV_M[HW-1:0];

    logic w_en;

    logic [LOG_W-1:0] w_log_num;
    logic [LOG_W-1:0] w_log_den;
    gcc_pkg::t_ctl    r_lc [NLAT];

    gcc_pkg::t_ctl    r_b_ctl;
    logic [LOG_W-1:0] r_b_mag;
    logic             r_b_neg;

    gcc_pkg::t_ctl    r_d_ctl [DIV_ST];
    logic [PM_W-1:0]  r_d_x [3];
    logic             r_d_neg [DIV_ST];
    logic [PHH_W-1:0] r_p_hh;
    logic [PHL_W-1:0] r_p_hl;
    logic [PLH_W-1:0] r_p_lh;
    logic [PLL_W-1:0] r_p_ll;
    logic [QUO_W-1:0] r_d_quo;
    logic [QUO_W-1:0] r_r_quo;
    logic             r_r_nz;

    gcc_pkg::t_ctl          r_q_ctl;
    logic signed [ZW-1:0]   r_q;

    gcc_pkg::t_ctl    r_x_ctl [FB+1];
    logic [30:0]      r_x_m [FB+1];
    logic [FB-1:0]    r_x_f [FB+1];
    logic [4:0]       r_x_ip [FB+1];

    logic                       r_out_valid;
    logic [gcc_pkg::CONC_W-1:0] r_out_conc;
    gcc_pkg::t_status           r_out_status;

    logic signed [ZW-1:0] w_zconst [8];

    assign w_en  = !r_out_valid || i_ready;
    assign o_pop = w_en && i_valid;

    gcc_log2 #(.NW(NW), .E_W(E_W)) u_log_num (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (i_num),
        .o_log (w_log_num)
    );

    gcc_log2 #(.NW(NW), .E_W(E_W)) u_log_den (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (i_den),
        .o_log (w_log_den)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NLAT; k++) r_lc[k].valid <= 1'b0;
        end else if (w_en) begin
            r_lc[0] <= '{valid: i_valid, kind: i_tag.kind, gas: i_tag.gas};
            for (int k = 1; k < NLAT; k++) r_lc[k] <= r_lc[k-1];
        end
    end

    // log ratio magnitude and sign
    logic signed [LOG_W:0] w_diff;
    assign w_diff = $signed({1'b0, w_log_num}) - $signed({1'b0, w_log_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl.valid <= 1'b0;
        end else if (w_en) begin
            r_b_ctl <= r_lc[NLAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_neg <= w_diff[LOG_W];
            r_b_mag <= w_diff[LOG_W] ? LOG_W'(-w_diff) : LOG_W'(w_diff);
        end
    end

    // exponent scaling
    logic [PM_W-1:0] w_prod;
    assign w_prod = r_b_mag * gcc_pkg::GAS_EXPO_MAG[r_b_ctl.gas];

    // divide by 1000 through a split reciprocal multiply, then rebuild the remainder
    logic [XH_W-1:0]  w_xh;
    logic [HW-1:0]    w_xl;
    logic [SUM_W-1:0] w_sum;
    logic [PM_W-1:0]  w_qback;

    assign w_xh    = r_d_x[0][PM_W-1:HW];
    assign w_xl    = r_d_x[0][HW-1:0];
    assign w_sum   = (SUM_W'(r_p_hh) << (2 * HW)) + (SUM_W'(r_p_hl) << HW) +
                     (SUM_W'(r_p_lh) << HW) + SUM_W'(r_p_ll);
    assign w_qback = PM_W'(r_d_quo) * PM_W'(gcc_pkg::EXPO_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_ST; k++) r_d_ctl[k].valid <= 1'b0;
        end else if (w_en) begin
            r_d_ctl[0] <= r_b_ctl;
            for (int k = 1; k < DIV_ST; k++) r_d_ctl[k] <= r_d_ctl[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_x[0]   <= w_prod;
            r_d_neg[0] <= r_b_neg ^ gcc_pkg::GAS_EXPO_NEG[r_b_ctl.gas];
            for (int k = 1; k < 3; k++) r_d_x[k] <= r_d_x[k-1];
            for (int k = 1; k < DIV_ST; k++) r_d_neg[k] <= r_d_neg[k-1];
            r_p_hh  <= PHH_W'(w_xh) * PHH_W'(DIV_MH);
            r_p_hl  <= PHL_W'(w_xh) * PHL_W'(DIV_ML);
            r_p_lh  <= PLH_W'(w_xl) * PLH_W'(DIV_MH);
            r_p_ll  <= PLL_W'(w_xl) * PLL_W'(DIV_ML);
            r_d_quo <= w_sum[DIV_S +: QUO_W];
            r_r_quo <= r_d_quo;
            r_r_nz  <= (r_d_x[2] != w_qback);
        end
    end

    // floor toward minus infinity
    logic signed [ZW-1:0] w_qpos;
    assign w_qpos = $signed(ZW'(r_r_quo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_ctl.valid <= 1'b0;
        end else if (w_en) begin
            r_q_ctl <= r_d_ctl[DIV_ST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_d_neg[DIV_ST-1]) begin
                r_q <= -(w_qpos + $signed(ZW'(r_r_nz)));
            end else begin
                r_q <= w_qpos;
            end
        end
    end

    // add coefficient log and output scaling, classify range
    for (genvar g = 0; g < 8; g++) begin : g_zc
        assign w_zconst[g] = ZW'(gcc_pkg::COEF_LOG[g]) + FRAC_OFF;
    end

    logic signed [ZW-1:0] w_z;
    gcc_pkg::t_ctl        w_zc;
    assign w_z = r_q + w_zconst[r_q_ctl.gas];

    always_comb begin
        w_zc = r_q_ctl;
        if (r_q_ctl.kind == gcc_pkg::KIND_NORM) begin
            if (w_z[ZW-1]) w_zc.kind = gcc_pkg::KIND_ZERO;
            else if (w_z[ZW-2:FB+5] != '0) w_zc.kind = gcc_pkg::KIND_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_ctl[0].valid <= 1'b0;
        end else if (w_en) begin
            r_x_ctl[0] <= w_zc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_m[0]  <= 31'(1) << FB;
            r_x_f[0]  <= w_z[FB-1:0];
            r_x_ip[0] <= w_z[FB+4:FB];
        end
    end

    // exp2 of the fraction, one factor per stage
    for (genvar k = 1; k <= FB; k++) begin : g_exp
        localparam logic [30:0] R_K = 31'(gcc_pkg::f_exp_r(k));
        logic [61:0] w_p;
        assign w_p = 62'(r_x_m[k-1]) * 62'(R_K);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_x_ctl[k].valid <= 1'b0;
            end else if (w_en) begin
                r_x_ctl[k] <= r_x_ctl[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_x_m[k]  <= r_x_f[k-1][FB-k] ? w_p[60:30] : r_x_m[k-1];
                r_x_f[k]  <= r_x_f[k-1];
                r_x_ip[k] <= r_x_ip[k-1];
            end
        end
    end

    // scale by the integer part and drive the output register
    logic [61:0] w_wide;
    assign w_wide = 62'(r_x_m[FB]) << r_x_ip[FB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_x_ctl[FB].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            unique case (r_x_ctl[FB].kind)
                gcc_pkg::KIND_INF: begin
                    r_out_conc   <= '1;
                    r_out_status <= gcc_pkg::STATUS_INF;
                end
                gcc_pkg::KIND_SAT: begin
                    r_out_conc   <= '1;
                    r_out_status <= gcc_pkg::STATUS_SAT;
                end
                gcc_pkg::KIND_ZERO: begin
                    r_out_conc   <= '0;
                    r_out_status <= gcc_pkg::STATUS_OK;
                end
                default: begin
                    r_out_conc   <= w_wide[61:30];
                    r_out_status <= gcc_pkg::STATUS_OK;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_concentration = r_out_conc;
    assign o_status        = r_out_status;

endmodule

// File: sv/gas_concentration_converter.sv
// Path from the input transaction to a valid result: front register, queue,
// 31-stage log2, log ratio register, four-stage reciprocal divide by 1000,
// floor register, 31-stage exp2, output register.
// Throughput: one transaction per cycle; the whole evaluation pipeline holds while the
// output register waits, and the four-entry queue keeps the front accepting until it fills.
// Reset: synchronous active low; baselines return to 512 and all pipeline valids clear.
`timescale 1ns / 1ps

module gas_concentration_converter #(
    parameter int ADC_FULL_SCALE = gcc_pkg::ADC_FULL_SCALE_DEF,
    parameter int FRAC_BITS      = gcc_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gcc_pkg::GAS_W-1:0]     i_gas_select,
    input  logic [gcc_pkg::READING_W-1:0] i_channel_reading,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [gcc_pkg::READING_W-1:0] i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gcc_pkg::CONC_W-1:0]    o_concentration,
    output logic [1:0]                    o_status
);

    localparam int FW = $clog2(ADC_FULL_SCALE + 1);
    localparam int NW = 2 * FW;
    localparam int TW = $bits(gcc_pkg::t_tag);
    localparam int QW = TW + 2 * NW;

    logic          w_push;
    logic          w_full;
    gcc_pkg::t_tag w_f_tag;
    logic [NW-1:0] w_f_num;
    logic [NW-1:0] w_f_den;
    logic [QW-1:0] w_q_out;
    logic          w_q_valid;
    logic          w_pop;

    gcc_front #(.ADC_FULL_SCALE(ADC_FULL_SCALE)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_gas_select      (i_gas_select),
        .i_channel_reading (i_channel_reading),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_push            (w_push),
        .i_full            (w_full),
        .o_tag             (w_f_tag),
        .o_num             (w_f_num),
        .o_den             (w_f_den)
    );

    gcc_fifo #(.WIDTH(QW), .DEPTH(gcc_pkg::FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_tag, w_f_num, w_f_den}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_valid (w_q_valid)
    );

    gcc_back #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .o_pop           (w_pop),
        .i_tag           (gcc_pkg::t_tag'(w_q_out[QW-1 -: TW])),
        .i_num           (w_q_out[2*NW-1:NW]),
        .i_den           (w_q_out[NW-1:0]),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_concentration (o_concentration),
        .o_status        (o_status)
    );

    a_flag_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == gcc_pkg::STATUS_INF || o_status == gcc_pkg::STATUS_SAT))
        |-> (&o_concentration))
        else $error("flagged result without all-ones concentration");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == gcc_pkg::STATUS_OK || o_status == gcc_pkg::STATUS_INF ||
                     o_status == gcc_pkg::STATUS_SAT))
        else $error("illegal status code");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

// File: tb/gas_concentration_converter_tb.sv
// Self-checking testbench for the gas concentration converter: random and directed stimulus.
`timescale 1ns / 1ps

module gas_concentration_converter_tb;

    typedef enum logic [2:0] {
        GAS_NH3, GAS_CO, GAS_NO2, GAS_C3H8, GAS_C4H10, GAS_CH4, GAS_H2, GAS_C2H5OH
    } t_gas;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int FULL = 1023;
    localparam int LAT = 130;
    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [31:0]      conc;
        gcc_pkg::t_status status;
    } t_result;

    class conc_scoreboard;
        t_result      expected_q[$];
        logic [9:0]   baseline[3];
        int           errors;
        int           checked;
        int           n_inf;
        int           n_sat;

        function new();
            baseline = '{gcc_pkg::BASELINE_RST, gcc_pkg::BASELINE_RST, gcc_pkg::BASELINE_RST};
        endfunction

        function void set_baseline(logic [1:0] idx, logic [9:0] val);
            if (idx != CFG_UNUSED) baseline[idx] = val;
        endfunction

        static function longint log2_q30(longint unsigned x);
            int e;
            longint unsigned m;
            longint unsigned f;
            e = 0;
            f = 0;
            for (int i = 63; i > 0; i--) begin
                if (x[i]) begin
                    e = i;
                    break;
                end
            end
            m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
            for (int i = 0; i < 30; i++) begin
                m = (m * m) >> 31;
                f = f << 1;
                if (m >= (64'd1 << 32)) begin
                    m = m >> 1;
                    f = f | 1;
                end
            end
            return (longint'(e) << 30) + longint'(f);
        endfunction

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        static function longint unsigned pow2_frac(longint unsigned f);
            longint unsigned m;
            longint unsigned r;
            m = 64'd1 << 30;
            r = int_sqrt(64'd2 << 60);
            for (int i = 1; i <= 30; i++) begin
                if (f[30 - i]) m = (m * r) >> 30;
                r = int_sqrt(r << 30);
            end
            return m;
        endfunction

        function void note_input(t_gas gas, logic [9:0] reading);
            int               chan_of[8] = '{0, 1, 2, 0, 0, 1, 1, 1};
            longint           expo_of[8] = '{-1670, -1179, 1007, -2518, -2138, -4363,
                                             -1800, -1552};
            longint unsigned  cnum_of[8] = '{100, 4385, 1000, 570164, 398107, 630957, 73, 1622};
            longint unsigned  cden_of[8] = '{147, 1000, 6855, 1000, 1000, 1000, 100, 1000};
            longint unsigned  a0;
            longint unsigned  an;
            longint unsigned  num;
            longint unsigned  den;
            longint unsigned  mant;
            longint unsigned  wide;
            longint           prod;
            longint           y;
            longint           z;
            longint           ip;
            t_result          res;
            a0  = baseline[chan_of[gas]];
            an  = reading;
            num = an * (FULL - a0);
            den = a0 * (FULL - an);
            if (den == 0) begin
                res = '{32'hFFFF_FFFF, gcc_pkg::STATUS_INF};
            end else if (num == 0) begin
                if (expo_of[gas] < 0) res = '{32'hFFFF_FFFF, gcc_pkg::STATUS_INF};
                else res = '{32'd0, gcc_pkg::STATUS_OK};
            end else begin
                prod = (log2_q30(num) - log2_q30(den)) * expo_of[gas];
                y = prod / 1000;
                if ((prod % 1000) != 0 && prod < 0) y = y - 1;
                y = y + log2_q30(cnum_of[gas]) - log2_q30(cden_of[gas]);
                z = y + (longint'(gcc_pkg::FRAC_BITS_DEF) << 30);
                if (z < 0) begin
                    res = '{32'd0, gcc_pkg::STATUS_OK};
                end else begin
                    ip = z >>> 30;
                    if (ip >= 32) begin
                        res = '{32'hFFFF_FFFF, gcc_pkg::STATUS_SAT};
                    end else begin
                        mant = pow2_frac(longint'(z) & ((64'd1 << 30) - 1));
                        wide = (ip >= 30) ? (mant << (ip - 30)) : (mant >> (30 - ip));
                        if (wide > 64'hFFFF_FFFF) res = '{32'hFFFF_FFFF, gcc_pkg::STATUS_SAT};
                        else res = '{wide[31:0], gcc_pkg::STATUS_OK};
                    end
                end
            end
            if (res.status == gcc_pkg::STATUS_INF) n_inf++;
            if (res.status == gcc_pkg::STATUS_SAT) n_sat++;
            expected_q.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got 0x%08h expected 0x%08h", what, got, want);
        endtask

        task check(logic [31:0] conc, logic [1:0] status);
            t_result want;
            checked++;
            if (expected_q.size() == 0) begin
                report("unexpected transaction", conc, 32'd0);
                return;
            end
            want = expected_q.pop_front();
            if (conc !== want.conc) report("concentration", conc, want.conc);
            if (status !== want.status) report("status", 32'(status), 32'(want.status));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_gas_select;
    logic [9:0]  i_channel_reading;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [9:0]  i_cfg_data;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_concentration;
    logic [1:0]  o_status;

    conc_scoreboard sb = new();
    bit          hold_req;
    int          idle_cycles;
    int          n_sent;

    gas_concentration_converter u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_gas_select      (i_gas_select),
        .i_channel_reading (i_channel_reading),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_concentration   (o_concentration),
        .o_status          (o_status)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: stall pattern plus one long hold-off on request
    initial begin
        int mode;
        int hold;
        i_ready = 1'b0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge i_clk);
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                2: i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check(o_concentration, o_status);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("FAIL gas_concentration_converter");
                $finish;
            end
        end
    end

    task automatic send(t_gas gas, logic [9:0] reading);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_gas_select <= gas;
        i_channel_reading <= reading;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(gas, reading);
        n_sent++;
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [9:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_baseline(idx, val);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    function automatic logic [9:0] pick_reading();
        case ($urandom_range(0, 7))
            0: return 10'd0;
            1: return 10'd1023;
            2: return 10'($urandom_range(0, 8));
            3: return 10'($urandom_range(1015, 1023));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic random_burst(int count);
        for (int k = 0; k < count; k++) send(t_gas'($urandom_range(0, 7)), pick_reading());
    endtask

    initial begin
        logic [9:0] edge_vals[4] = '{10'd0, 10'd1, 10'd1023, 10'd512};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_gas_select = '0;
        i_channel_reading = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = gcc_pkg::CFG_NH3;
        i_cfg_data = '0;
        hold_req = 1'b0;
        idle_cycles = 0;
        n_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every gas at the reading extremes and one random mid-range reading, reset baselines
        for (int g = 0; g < 8; g++) begin
            send(t_gas'(g), 10'd0);
            send(t_gas'(g), 10'd1023);
            send(t_gas'(g), 10'($urandom_range(1, 1022)));
        end
        random_burst(100);
        drain();

        // zero baseline, full-scale baseline, tiny baseline
        cfg_write(gcc_pkg::CFG_NH3, 10'd0);
        cfg_write(gcc_pkg::CFG_CO, 10'd1023);
        cfg_write(gcc_pkg::CFG_NO2, 10'd1);
        for (int g = 0; g < 8; g++) send(t_gas'(g), edge_vals[g % 4]);
        random_burst(80);
        drain();

        cfg_write(gcc_pkg::CFG_NH3, 10'd1022);
        cfg_write(gcc_pkg::CFG_CO, 10'd1);
        cfg_write(gcc_pkg::CFG_NO2, 10'd1023);
        cfg_write(CFG_UNUSED, 10'd0);
        random_burst(100);
        drain();

        for (int p = 0; p < 3; p++) begin
            cfg_write(gcc_pkg::CFG_NH3, 10'($urandom_range(0, 1023)));
            cfg_write(gcc_pkg::CFG_CO, 10'($urandom_range(0, 1023)));
            cfg_write(gcc_pkg::CFG_NO2, 10'($urandom_range(0, 1023)));
            if (p == 1) hold_req = 1'b1;
            random_burst(100);
            drain();
        end

        $display("covered %0d transactions over several baseline settings, %0d checked",
                 n_sent, sb.checked);
        $display("infinite results %0d, saturated results %0d", sb.n_inf, sb.n_sat);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASS gas_concentration_converter");
        end else begin
            $display("FAIL gas_concentration_converter");
        end
        $finish;
    end

endmodule
